FILE: hdl/wgs_pkg.sv
// Shared types, constants and helper functions for the wave grid stencil block.
// Used by wgs_cfg, wgs_mac and wave_grid_stencil_step; depends on nothing else.
package wgs_pkg;

    // Grid geometry and arithmetic widths.
    localparam int HEIGHT_W = 16;
    localparam int ROW_W    = 7;
    localparam int COL_W    = 7;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int CELLS    = 1 << ADDR_W;
    localparam int MAX_ROWS = 1 << ROW_W;
    localparam int MAX_COLS = 1 << COL_W;
    localparam int DIM_W    = 8;
    localparam int COEF_W   = 16;
    localparam int NSUM_W   = HEIGHT_W + 2;
    localparam int PROD_W   = COEF_W + NSUM_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int COEF_FRAC = 13;
    localparam int TIME_W   = 16;
    localparam int TACC_W   = 17;

    // Stream payload widths.
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_K1        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_K2        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_K3        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROWS_USED = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COLS_USED = 3'd5;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_DISTURB = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sh7FFF;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 16'sh8000;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
        logic [TIME_W-1:0]        time_step;
        logic [DIM_W-1:0]         rows_used;
        logic [DIM_W-1:0]         cols_used;
    } t_cfg;

    // Controls for the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

    // Saturating height addition.
    function automatic logic signed [HEIGHT_W-1:0] sat_add(
        input logic signed [HEIGHT_W-1:0] a,
        input logic signed [HEIGHT_W-1:0] b
    );
        logic [HEIGHT_W:0] s;
        s = {a[HEIGHT_W-1], a} + {b[HEIGHT_W-1], b};
        if (s[HEIGHT_W] != s[HEIGHT_W-1]) begin
            return s[HEIGHT_W] ? HEIGHT_MIN : HEIGHT_MAX;
        end
        return s[HEIGHT_W-1:0];
    endfunction

endpackage

FILE: hdl/wgs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module wgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/wgs_cfg.sv
// APB register file holding the stencil weights, time step and grid size.
// Depends on wgs_pkg for the register map and the t_cfg struct.
module wgs_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wgs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wgs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wgs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output wgs_pkg::t_cfg                     o_cfg
);

    wgs_pkg::t_cfg                    r_cfg;
    logic [wgs_pkg::REG_IDX_W-1:0]    w_idx;
    logic                             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[wgs_pkg::APB_ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k1        <= -16'sd8192;
            r_cfg.k2        <= 16'sd15360;
            r_cfg.k3        <= 16'sd1024;
            r_cfg.time_step <= 16'd100;
            r_cfg.rows_used <= 8'd128;
            r_cfg.cols_used <= 8'd128;
        end else if (w_wr) begin
            unique case (w_idx)
                wgs_pkg::REG_K1:        r_cfg.k1        <= pwdata[15:0];
                wgs_pkg::REG_K2:        r_cfg.k2        <= pwdata[15:0];
                wgs_pkg::REG_K3:        r_cfg.k3        <= pwdata[15:0];
                wgs_pkg::REG_TIME_STEP: r_cfg.time_step <= pwdata[15:0];
                wgs_pkg::REG_ROWS_USED: r_cfg.rows_used <= pwdata[7:0];
                wgs_pkg::REG_COLS_USED: r_cfg.cols_used <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_idx)
            wgs_pkg::REG_K1:        prdata = {16'd0, r_cfg.k1};
            wgs_pkg::REG_K2:        prdata = {16'd0, r_cfg.k2};
            wgs_pkg::REG_K3:        prdata = {16'd0, r_cfg.k3};
            wgs_pkg::REG_TIME_STEP: prdata = {16'd0, r_cfg.time_step};
            wgs_pkg::REG_ROWS_USED: prdata = {24'd0, r_cfg.rows_used};
            wgs_pkg::REG_COLS_USED: prdata = {24'd0, r_cfg.cols_used};
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/wgs_mac.sv
// Shared multiply-accumulate unit with rounding and saturation to a height.
// Depends on wgs_pkg for widths and the t_mac_ctl struct.
module wgs_mac (
    input  logic                                    i_clk,
    input  wgs_pkg::t_mac_ctl                       i_ctl,
    input  logic signed [wgs_pkg::COEF_W-1:0]       i_coef,
    input  logic signed [wgs_pkg::NSUM_W-1:0]       i_opnd,
    output logic signed [wgs_pkg::HEIGHT_W-1:0]     o_height
);

    logic signed [wgs_pkg::PROD_W-1:0] r_prod;
    logic signed [wgs_pkg::ACC_W-1:0]  r_acc;
    logic signed [wgs_pkg::ACC_W-1:0]  w_rnd;
    logic signed [wgs_pkg::ACC_W-1:0]  w_shr;

    // Registered product, then accumulate on the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= wgs_pkg::PROD_W'(i_coef) * wgs_pkg::PROD_W'(i_opnd);
        end
        if (i_ctl.acc_load) begin
            r_acc <= wgs_pkg::ACC_W'(r_prod);
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + wgs_pkg::ACC_W'(r_prod);
        end
    end

    // Round half up to the height fraction, then saturate.
    assign w_rnd = r_acc + wgs_pkg::ACC_W'(1 << (wgs_pkg::COEF_FRAC - 1));
    assign w_shr = w_rnd >>> wgs_pkg::COEF_FRAC;

    always_comb begin
        if (w_shr > wgs_pkg::ACC_W'(wgs_pkg::HEIGHT_MAX)) begin
            o_height = wgs_pkg::HEIGHT_MAX;
        end else if (w_shr < wgs_pkg::ACC_W'(wgs_pkg::HEIGHT_MIN)) begin
            o_height = wgs_pkg::HEIGHT_MIN;
        end else begin
            o_height = w_shr[wgs_pkg::HEIGHT_W-1:0];
        end
    end

endmodule

FILE: hdl/wave_grid_stencil_step.sv
// Top level of the 2-D wave equation grid: sequencer, grid memories, MAC and registers.
// Depends on wgs_pkg, wgs_ram, wgs_cfg and wgs_mac.
//
// The block holds two 128x128 height grids in Q7.8 and takes one command beat at a
// time: advance, disturb or read, each answered by exactly one result beat. After
// reset the block sweeps all 16384 cells of both grid memories to zero, one cell per
// cycle, before it accepts the first command (register writes are taken meanwhile).
// An advance that steps on a used grid of at least 3x3 runs the stencil over every
// interior cell in turn, reading the taps, multiplying, accumulating and writing back;
// its pace is set by the single read port of the current-grid memory, which delivers
// the five stencil taps one after another, and the one shared multiplier, which forms
// the three weighted terms in turn. The result beat waits in an output register, so a
// new command is taken while the previous result is still pending.
module wave_grid_stencil_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command stream. tdata: row[6:0], col[13:7], magnitude[29:14], elapsed[45:30].
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [wgs_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [wgs_pkg::S_USER_W-1:0]       s_axis_tuser,
    // Result stream. tdata: height[15:0].
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [wgs_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // tuser: stepped[0], status[1].
    output logic [wgs_pkg::M_USER_W-1:0]       m_axis_tuser,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wgs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wgs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wgs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int HW = wgs_pkg::HEIGHT_W;
    localparam int AW = wgs_pkg::ADDR_W;
    localparam int RW = wgs_pkg::ROW_W;
    localparam int CW = wgs_pkg::COL_W;
    localparam int DW = wgs_pkg::DIM_W;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_DRD   = 3'd3;
    localparam logic [2:0] S_DWR   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Per-cell phases of a grid step.
    localparam logic [3:0] PH_RD_UP    = 4'd0;
    localparam logic [3:0] PH_RD_DN    = 4'd1;
    localparam logic [3:0] PH_RD_LT    = 4'd2;
    localparam logic [3:0] PH_RD_RT    = 4'd3;
    localparam logic [3:0] PH_RD_MID   = 4'd4;
    localparam logic [3:0] PH_MUL_PREV = 4'd5;
    localparam logic [3:0] PH_MUL_MID  = 4'd6;
    localparam logic [3:0] PH_MUL_NB   = 4'd7;
    localparam logic [3:0] PH_ACC_NB   = 4'd8;
    localparam logic [3:0] PH_WRITE    = 4'd9;

    localparam logic [2:0] D_LAST = 3'd4;

    wgs_pkg::t_cfg                          w_cfg;
    wgs_pkg::t_mac_ctl                      w_mac_ctl;
    logic signed [wgs_pkg::COEF_W-1:0]      w_mac_coef;
    logic signed [wgs_pkg::NSUM_W-1:0]      w_mac_opnd;
    logic signed [HW-1:0]                   w_mac_height;

    logic [2:0]                   r_state;
    logic [3:0]                   r_phase;
    logic [AW-1:0]                r_clr;
    logic                         r_cur_b;
    logic [wgs_pkg::TACC_W-1:0]   r_tacc;
    logic [wgs_pkg::TACC_W-1:0]   n_tacc;

    logic [RW-1:0]                r_row;
    logic [CW-1:0]                r_col;
    logic signed [HW-1:0]         r_mag;
    logic [RW-1:0]                r_r;
    logic [CW-1:0]                r_c;
    logic [2:0]                   r_didx;
    logic signed [wgs_pkg::NSUM_W-1:0] r_nsum;
    logic signed [HW-1:0]         r_prevh;
    logic signed [HW-1:0]         r_center;

    logic signed [HW-1:0]         r_res_height;
    logic                         r_res_stepped;
    logic                         r_res_status;
    logic                         r_out_valid;
    logic signed [HW-1:0]         r_out_height;
    logic                         r_out_stepped;
    logic                         r_out_status;

    logic                         w_in_acc;
    logic [1:0]                   w_op;
    logic [RW-1:0]                w_row;
    logic [CW-1:0]                w_col;
    logic signed [HW-1:0]         w_mag;
    logic [wgs_pkg::TIME_W-1:0]   w_elapsed;
    logic [DW-1:0]                w_nr;
    logic [DW-1:0]                w_nc;
    logic                         w_grid_ok;
    logic                         w_dist_ok;
    logic                         w_read_ok;
    logic                         w_step_hit;
    logic                         w_last_col;
    logic                         w_last_row;

    logic [AW-1:0]                w_cell;
    logic [AW-1:0]                w_daddr;
    logic signed [HW-1:0]         w_dval;
    logic signed [HW-1:0]         w_dsum;

    logic [AW-1:0]                w_curr_raddr;
    logic [AW-1:0]                w_prev_raddr;
    logic                         w_curr_we;
    logic                         w_prev_we;
    logic                         w_clearing;
    logic signed [HW-1:0]         w_curr_rdata;
    logic signed [HW-1:0]         w_prev_rdata;

    logic                         w_a_we;
    logic [AW-1:0]                w_a_waddr;
    logic [HW-1:0]                w_a_wdata;
    logic [AW-1:0]                w_a_raddr;
    logic [HW-1:0]                w_a_rdata;
    logic                         w_b_we;
    logic [AW-1:0]                w_b_waddr;
    logic [HW-1:0]                w_b_wdata;
    logic [AW-1:0]                w_b_raddr;
    logic [HW-1:0]                w_b_rdata;

    // Register file.
    wgs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input beat fields.
    assign w_op      = s_axis_tuser[1:0];
    assign w_row     = s_axis_tdata[6:0];
    assign w_col     = s_axis_tdata[13:7];
    assign w_mag     = s_axis_tdata[29:14];
    assign w_elapsed = s_axis_tdata[45:30];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;

    // Used grid size, limited to the memory geometry.
    assign w_nr = (w_cfg.rows_used > DW'(wgs_pkg::MAX_ROWS)) ?
                  DW'(wgs_pkg::MAX_ROWS) : w_cfg.rows_used;
    assign w_nc = (w_cfg.cols_used > DW'(wgs_pkg::MAX_COLS)) ?
                  DW'(wgs_pkg::MAX_COLS) : w_cfg.cols_used;

    assign w_grid_ok = (w_nr >= 8'd3) && (w_nc >= 8'd3);
    assign w_dist_ok = ({1'b0, w_row} > 8'd1) && (({1'b0, w_row} + 8'd2) < w_nr) &&
                       ({1'b0, w_col} > 8'd1) && (({1'b0, w_col} + 8'd2) < w_nc);
    assign w_read_ok = ({1'b0, w_row} < w_nr) && ({1'b0, w_col} < w_nc);

    // Time accumulator wraps at its width.
    assign n_tacc     = r_tacc + {1'b0, w_elapsed};
    assign w_step_hit = n_tacc >= {1'b0, w_cfg.time_step};

    // Stencil scan position.
    assign w_cell     = {r_r, r_c};
    assign w_last_col = ({1'b0, r_c} + 8'd2) >= w_nc;
    assign w_last_row = ({1'b0, r_r} + 8'd2) >= w_nr;

    // Disturb cell: center, right, left, below, above.
    always_comb begin
        case (r_didx)
            3'd1:    w_daddr = {r_row, r_col + 7'd1};
            3'd2:    w_daddr = {r_row, r_col - 7'd1};
            3'd3:    w_daddr = {r_row + 7'd1, r_col};
            3'd4:    w_daddr = {r_row - 7'd1, r_col};
            default: w_daddr = {r_row, r_col};
        endcase
    end

    assign w_dval = (r_didx == 3'd0) ? r_mag : (r_mag >>> 1);
    assign w_dsum = wgs_pkg::sat_add(w_curr_rdata, w_dval);

    // Memory read addresses, write enables and MAC control per state and phase.
    always_comb begin
        w_curr_raddr = {w_row, w_col};
        w_prev_raddr = w_cell;
        w_curr_we    = 1'b0;
        w_prev_we    = 1'b0;
        w_mac_ctl    = '0;
        w_mac_coef   = w_cfg.k1;
        w_mac_opnd   = wgs_pkg::NSUM_W'(r_prevh);
        unique case (r_state)
            S_STEP: begin
                case (r_phase)
                    PH_RD_UP:  w_curr_raddr = {r_r - 7'd1, r_c};
                    PH_RD_DN:  w_curr_raddr = {r_r + 7'd1, r_c};
                    PH_RD_LT:  w_curr_raddr = {r_r, r_c - 7'd1};
                    PH_RD_RT:  w_curr_raddr = {r_r, r_c + 7'd1};
                    PH_RD_MID: w_curr_raddr = w_cell;
                    PH_MUL_PREV: begin
                        w_mac_ctl.mul_en = 1'b1;
                    end
                    PH_MUL_MID: begin
                        w_mac_ctl.mul_en   = 1'b1;
                        w_mac_ctl.acc_load = 1'b1;
                        w_mac_coef         = w_cfg.k2;
                        w_mac_opnd         = wgs_pkg::NSUM_W'(r_center);
                    end
                    PH_MUL_NB: begin
                        w_mac_ctl.mul_en  = 1'b1;
                        w_mac_ctl.acc_add = 1'b1;
                        w_mac_coef        = w_cfg.k3;
                        w_mac_opnd        = r_nsum;
                    end
                    PH_ACC_NB: w_mac_ctl.acc_add = 1'b1;
                    PH_WRITE:  w_prev_we = 1'b1;
                    default: ;
                endcase
            end
            S_DRD:   w_curr_raddr = w_daddr;
            S_DWR:   w_curr_we    = 1'b1;
            default: ;
        endcase
    end

    // Map the current and previous roles onto the two grid memories.
    assign w_clearing = (r_state == S_CLEAR);

    assign w_a_we    = w_clearing | (r_cur_b ? w_prev_we : w_curr_we);
    assign w_a_waddr = w_clearing ? r_clr : (r_cur_b ? w_cell : w_daddr);
    assign w_a_wdata = w_clearing ? '0 : (r_cur_b ? w_mac_height : w_dsum);
    assign w_a_raddr = r_cur_b ? w_prev_raddr : w_curr_raddr;

    assign w_b_we    = w_clearing | (r_cur_b ? w_curr_we : w_prev_we);
    assign w_b_waddr = w_clearing ? r_clr : (r_cur_b ? w_daddr : w_cell);
    assign w_b_wdata = w_clearing ? '0 : (r_cur_b ? w_dsum : w_mac_height);
    assign w_b_raddr = r_cur_b ? w_curr_raddr : w_prev_raddr;

    assign w_curr_rdata = r_cur_b ? w_b_rdata : w_a_rdata;
    assign w_prev_rdata = r_cur_b ? w_a_rdata : w_b_rdata;

    wgs_ram #(
        .WIDTH (wgs_pkg::HEIGHT_W),
        .DEPTH (wgs_pkg::CELLS)
    ) u_grid_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (w_a_wdata),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    wgs_ram #(
        .WIDTH (wgs_pkg::HEIGHT_W),
        .DEPTH (wgs_pkg::CELLS)
    ) u_grid_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // Shared multiply-accumulate unit.
    wgs_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_mac_ctl),
        .i_coef   (w_mac_coef),
        .i_opnd   (w_mac_opnd),
        .o_height (w_mac_height)
    );

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_RD_UP;
            r_clr       <= '0;
            r_cur_b     <= 1'b0;
            r_tacc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills when a result leaves S_OUT and empties when
            // its beat is taken.
            if ((r_state == S_OUT) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (w_op)
                            wgs_pkg::OP_ADVANCE: begin
                                if (w_step_hit) begin
                                    if (w_grid_ok) begin
                                        r_phase <= PH_RD_UP;
                                        r_state <= S_STEP;
                                    end else begin
                                        r_cur_b <= ~r_cur_b;
                                        r_tacc  <= '0;
                                        r_state <= S_OUT;
                                    end
                                end else begin
                                    r_tacc  <= n_tacc;
                                    r_state <= S_OUT;
                                end
                            end
                            wgs_pkg::OP_DISTURB: begin
                                r_state <= w_dist_ok ? S_DRD : S_OUT;
                            end
                            wgs_pkg::OP_READ: begin
                                r_state <= w_read_ok ? S_READ : S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_STEP: begin
                    if (r_phase == PH_WRITE) begin
                        r_phase <= PH_RD_UP;
                        if (w_last_col && w_last_row) begin
                            r_cur_b <= ~r_cur_b;
                            r_tacc  <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_phase <= r_phase + 4'd1;
                    end
                end
                S_DRD: r_state <= S_DWR;
                S_DWR: r_state <= (r_didx == D_LAST) ? S_OUT : S_DRD;
                S_READ: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item, scan and result payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_row         <= w_row;
                    r_col         <= w_col;
                    r_mag         <= w_mag;
                    r_r           <= 7'd1;
                    r_c           <= 7'd1;
                    r_didx        <= 3'd0;
                    r_res_height  <= '0;
                    r_res_stepped <= (w_op == wgs_pkg::OP_ADVANCE) && w_step_hit;
                    r_res_status  <= (w_op == wgs_pkg::OP_DISTURB) && !w_dist_ok;
                end
            end
            S_STEP: begin
                case (r_phase)
                    PH_RD_DN: begin
                        r_nsum  <= wgs_pkg::NSUM_W'(w_curr_rdata);
                        r_prevh <= w_prev_rdata;
                    end
                    PH_RD_LT, PH_RD_RT, PH_RD_MID: begin
                        r_nsum <= r_nsum + wgs_pkg::NSUM_W'(w_curr_rdata);
                    end
                    PH_MUL_PREV: r_center <= w_curr_rdata;
                    PH_WRITE: begin
                        if (w_last_col) begin
                            r_c <= 7'd1;
                            r_r <= r_r + 7'd1;
                        end else begin
                            r_c <= r_c + 7'd1;
                        end
                    end
                    default: ;
                endcase
            end
            S_DWR:  r_didx <= r_didx + 3'd1;
            S_READ: r_res_height <= w_curr_rdata;
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_height  <= r_res_height;
                    r_out_stepped <= r_res_stepped;
                    r_out_status  <= r_res_status;
                end
            end
            default: ;
        endcase
    end

    // Result beat.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_height;
    assign m_axis_tuser  = {r_out_status, r_out_stepped};

endmodule
